// ===== src/pidc_pkg.sv =====
// Shared widths, constants, payload types and saturation helpers for the
// clamped PID controller. No dependencies; the controller and the multiplier import this package.
`default_nettype none

package pidc_pkg;

  localparam int unsigned ValW     = 32;
  localparam int unsigned GainW    = 24;
  localparam int unsigned LimW     = 31;
  localparam int unsigned CoefW    = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;
  localparam int unsigned MulAW    = 33;
  localparam int unsigned ProdW    = MulAW + GainW + 1;
  localparam int unsigned AccW     = 44;

  // Fixed limits of the controller.
  localparam logic [LimW-1:0]  D_LIMIT       = 31'd6553600;
  localparam logic [LimW-1:0]  STEP_LIMIT    = 31'd655360;
  localparam logic [LimW-1:0]  TARGET_LIMIT  = 31'd6553600;
  localparam logic [CoefW-1:0] TARGET_FILTER = 17'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KP,
    REG_KI_DT,
    REG_KD_DT,
    REG_KF_DT,
    REG_SEP_THR,
    REG_INT_LIM,
    REG_OUT_LIM,
    REG_OUT_COEF
  } cfg_reg_e;

  typedef struct packed {
    logic signed [ValW-1:0] feedback_value;
    logic signed [ValW-1:0] target_value;
    logic                   target_update;
  } pidc_in_t;

  typedef struct packed {
    logic signed [ValW-1:0] drive_value;
    logic signed [ValW-1:0] filtered_target;
    logic signed [ValW-1:0] error_value;
  } pidc_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } pidc_cfg_t;

  // Sign-extend a 32-bit value to the accumulator width.
  function automatic logic signed [AccW-1:0] sx32(input logic [ValW-1:0] v);
    return {{(AccW-ValW){v[ValW-1]}}, v};
  endfunction

  // Clamp to the symmetric range -lim..lim.
  function automatic logic signed [AccW-1:0] clamp_sym(input logic signed [AccW-1:0] v,
                                                        input logic [LimW-1:0] lim);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = $signed({{(AccW-LimW){1'b0}}, lim});
    lo = -hi;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  // Saturate to the signed 32-bit range.
  function automatic logic signed [ValW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = $signed({{(AccW-ValW){1'b0}}, 32'h7FFF_FFFF});
    lo = $signed({{(AccW-ValW){1'b1}}, 32'h8000_0000});
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[ValW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/pidc_stream_if.sv =====
// Valid/ready channel interface carrying one payload of type T.
// Used for the input, result and configuration channels; payload types come from pidc_pkg.
`default_nettype none

interface pidc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/pid_controller_clamped_ff.sv =====
// Clamped PID controller with integral separation, feedforward and a filtered drive.
// The sequencer runs thirteen steps around one multiplier after the idle state in which
// the input is taken; no new input is taken until it returns to idle, and the last
// step waits while the result register is still full.
// The result register lets the next input start while a result waits to be taken.
// Reset (async, active low) clears the gain registers, the controller state and the channels.
`default_nettype none

module pid_controller_clamped_ff import pidc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  pidc_stream_if.sink   in_i,
  pidc_stream_if.source out_o,
  pidc_stream_if.sink   cfg_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_MT, S_UT, S_ERR, S_MI, S_MP, S_MD,
    S_MF, S_SUM, S_CLP, S_DIF, S_MO, S_STP, S_DRV
  } state_e;

  state_e state_q, state_d;

  logic [GainW-1:0] kp_q, kp_d, ki_q, ki_d, kd_q, kd_d, kf_q, kf_d;
  logic [LimW-1:0]  sep_q, sep_d, int_lim_q, int_lim_d, out_lim_q, out_lim_d;
  logic [CoefW-1:0] coef_q, coef_d;

  logic signed [ValW-1:0] target_now_q, target_now_d, target_prev_q, target_prev_d;
  logic signed [ValW-1:0] error_prev_q, error_prev_d, integral_q, integral_d;
  logic signed [ValW-1:0] drive_q, drive_d, err_q, err_d, fb_q, fb_d;
  logic                   upd_q, upd_d, sep_ok_q, sep_ok_d;
  logic signed [MulAW-1:0] diff_q, diff_d;
  logic signed [AccW-1:0]  acc_q, acc_d;

  logic      out_valid_q, out_valid_d;
  pidc_out_t out_q, out_d;

  logic signed [MulAW-1:0] mul_a;
  logic        [GainW-1:0] mul_g;
  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  prod_q16;
  logic signed [AccW-1:0]  tgt_clamped;
  logic        [ValW-1:0]  err_mag;
  logic                    in_fire;
  logic                    out_free;

  pidc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .g_i    (mul_g),
    .prod_o (prod)
  );

  // Floor of product / 65536.
  assign prod_q16 = {{(AccW-(ProdW-16)){prod[ProdW-1]}}, prod[ProdW-1:16]};

  assign in_fire     = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign tgt_clamped = clamp_sym(sx32(in_i.payload.target_value), TARGET_LIMIT);
  assign err_mag     = err_q[ValW-1] ? (~err_q + 32'd1) : err_q;

  assign in_i.ready    = (state_q == S_IDLE);
  assign cfg_i.ready   = 1'b1;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_comb begin
    mul_a = diff_q;
    if (state_q == S_MI || state_q == S_MP) begin
      mul_a = {err_q[ValW-1], err_q};
    end
    case (state_q)
      S_MT:    mul_g = {{(GainW-CoefW){1'b0}}, TARGET_FILTER};
      S_MI:    mul_g = ki_q;
      S_MP:    mul_g = kp_q;
      S_MD:    mul_g = kd_q;
      S_MF:    mul_g = kf_q;
      S_MO:    mul_g = {{(GainW-CoefW){1'b0}}, coef_q};
      default: mul_g = '0;
    endcase
  end

  always_comb begin
    kp_d = kp_q; ki_d = ki_q; kd_d = kd_q; kf_d = kf_q;
    sep_d = sep_q; int_lim_d = int_lim_q; out_lim_d = out_lim_q; coef_d = coef_q;
    if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_reg_e'(cfg_i.payload.index))
        REG_KP:       kp_d      = cfg_i.payload.data[GainW-1:0];
        REG_KI_DT:    ki_d      = cfg_i.payload.data[GainW-1:0];
        REG_KD_DT:    kd_d      = cfg_i.payload.data[GainW-1:0];
        REG_KF_DT:    kf_d      = cfg_i.payload.data[GainW-1:0];
        REG_SEP_THR:  sep_d     = cfg_i.payload.data[LimW-1:0];
        REG_INT_LIM:  int_lim_d = cfg_i.payload.data[LimW-1:0];
        REG_OUT_LIM:  out_lim_d = cfg_i.payload.data[LimW-1:0];
        REG_OUT_COEF: coef_d    = cfg_i.payload.data[CoefW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d       = state_q;
    target_now_d  = target_now_q;
    target_prev_d = target_prev_q;
    error_prev_d  = error_prev_q;
    integral_d    = integral_q;
    drive_d       = drive_q;
    err_d         = err_q;
    fb_d          = fb_q;
    upd_d         = upd_q;
    sep_ok_d      = sep_ok_q;
    diff_d        = diff_q;
    acc_d         = acc_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && !out_o.ready;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          fb_d    = in_i.payload.feedback_value;
          upd_d   = in_i.payload.target_update;
          diff_d  = tgt_clamped[MulAW-1:0] - {target_now_q[ValW-1], target_now_q};
          state_d = S_MT;
        end
      end
      S_MT: state_d = S_UT;
      S_UT: begin
        if (upd_q) begin
          target_prev_d = target_now_q;
          target_now_d  = sat32(sx32(target_now_q) + prod_q16);
        end
        state_d = S_ERR;
      end
      S_ERR: begin
        err_d   = sat32(sx32(target_now_q) - sx32(fb_q));
        state_d = S_MI;
      end
      S_MI: begin
        sep_ok_d = err_mag < {1'b0, sep_q};
        diff_d   = {err_q[ValW-1], err_q} - {error_prev_q[ValW-1], error_prev_q};
        state_d  = S_MP;
      end
      S_MP: begin
        integral_d   = ValW'(clamp_sym(sx32(integral_q) + (sep_ok_q ? prod_q16 : '0),
                                       int_lim_q));
        error_prev_d = err_q;
        state_d      = S_MD;
      end
      S_MD: begin
        // P plus the freshly clamped integral.
        acc_d   = prod_q16 + sx32(integral_q);
        diff_d  = {target_now_q[ValW-1], target_now_q} -
                  {target_prev_q[ValW-1], target_prev_q};
        state_d = S_MF;
      end
      S_MF: begin
        acc_d   = acc_q + clamp_sym(prod_q16, D_LIMIT);
        state_d = S_SUM;
      end
      S_SUM: begin
        acc_d   = acc_q + prod_q16;
        state_d = S_CLP;
      end
      S_CLP: begin
        acc_d   = clamp_sym(acc_q, out_lim_q);
        state_d = S_DIF;
      end
      S_DIF: begin
        diff_d  = acc_q[MulAW-1:0] - {drive_q[ValW-1], drive_q};
        state_d = S_MO;
      end
      S_MO: state_d = S_STP;
      S_STP: begin
        acc_d   = clamp_sym(prod_q16, STEP_LIMIT);
        state_d = S_DRV;
      end
      S_DRV: begin
        // Wait here until the result register is free, so the drive is updated once.
        if (out_free) begin
          drive_d               = sat32(sx32(drive_q) + acc_q);
          out_d.drive_value     = drive_d;
          out_d.filtered_target = target_now_q;
          out_d.error_value     = err_q;
          out_valid_d           = 1'b1;
          state_d               = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      kp_q          <= '0;
      ki_q          <= '0;
      kd_q          <= '0;
      kf_q          <= '0;
      sep_q         <= '0;
      int_lim_q     <= '0;
      out_lim_q     <= '0;
      coef_q        <= '0;
      target_now_q  <= '0;
      target_prev_q <= '0;
      error_prev_q  <= '0;
      integral_q    <= '0;
      drive_q       <= '0;
      err_q         <= '0;
      fb_q          <= '0;
      upd_q         <= 1'b0;
      sep_ok_q      <= 1'b0;
      diff_q        <= '0;
      acc_q         <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      state_q       <= state_d;
      kp_q          <= kp_d;
      ki_q          <= ki_d;
      kd_q          <= kd_d;
      kf_q          <= kf_d;
      sep_q         <= sep_d;
      int_lim_q     <= int_lim_d;
      out_lim_q     <= out_lim_d;
      coef_q        <= coef_d;
      target_now_q  <= target_now_d;
      target_prev_q <= target_prev_d;
      error_prev_q  <= error_prev_d;
      integral_q    <= integral_d;
      drive_q       <= drive_d;
      err_q         <= err_d;
      fb_q          <= fb_d;
      upd_q         <= upd_d;
      sep_ok_q      <= sep_ok_d;
      diff_q        <= diff_d;
      acc_q         <= acc_d;
      out_valid_q   <= out_valid_d;
      out_q         <= out_d;
    end
  end

  localparam logic signed [ValW-1:0] TgtHi = {1'b0, TARGET_LIMIT};
  localparam logic signed [ValW-1:0] TgtLo = -TgtHi;

  a_result_from_drive_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DRV))
    else $error("result became valid outside the drive update step");

  a_accept_starts_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_MT))
    else $error("accepted input did not start the sequencer");

  a_target_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (target_now_q <= TgtHi) && (target_now_q >= TgtLo))
    else $error("filtered target left the target clamp range");

endmodule

`default_nettype wire

// ===== src/pidc_mul.sv =====
// Shared registered multiplier: signed 33-bit operand times unsigned 24-bit gain.
// Depends on pidc_pkg for widths; the product is registered, so it appears in the cycle after the operands.
`default_nettype none

module pidc_mul import pidc_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [MulAW-1:0]  a_i,
  input  logic        [GainW-1:0]  g_i,
  output logic signed [ProdW-1:0]  prod_o
);

  logic signed [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * $signed({1'b0, g_i});
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire
